// ===== hw/rtl/pcse_pkg.sv =====
package pcse_pkg;

  localparam int unsigned MAX_CH   = 4;
  localparam int unsigned CH_W     = 2;
  localparam int unsigned DIVD_W   = 64;
  localparam int unsigned DIVS_W   = 48;
  localparam logic [31:0] PRESC_OVER = 32'hffff_0000;

  typedef enum logic [1:0] {
    OP_CONFIG = 2'd0,
    OP_START  = 2'd1,
    OP_STOP   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOTSUP  = 2'd2,
    ST_RANGE   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_CORE_NUM = 2'd0,
    REG_CORE_DEN = 2'd1,
    REG_WIDE     = 2'd2,
    REG_REMAP    = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DIV_SCALE  = 2'd0,
    DIV_PERIOD = 2'd1,
    DIV_DUTY   = 2'd2
  } div_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FMUL,
    S_FDIV_S,
    S_FDIV_W,
    S_PDIV_S,
    S_PDIV_W,
    S_CHAN,
    S_DMUL,
    S_DDIV_S,
    S_DDIV_W,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  ch_mask;
    logic        set_freq;
    logic        set_duty;
    logic        set_polarity;
    logic [31:0] freq_num;
    logic [15:0] freq_den;
    logic [31:0] duty_num;
    logic [31:0] duty_den;
    logic        active_high;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] prescaler;
    logic [31:0] period;
    logic [31:0] compare_ch0;
    logic [31:0] compare_ch1;
    logic [31:0] compare_ch2;
    logic [31:0] compare_ch3;
    logic [3:0]  enable_mask;
    logic [3:0]  low_polarity_mask;
    logic        running;
  } out_t;

  typedef struct packed {
    logic     latch;
    logic     do_start;
    logic     do_stop;
    logic     load_fmul;
    logic     div_start;
    div_sel_e div_sel;
    logic     latch_scale;
    logic     write_freq;
    logic     ch_clear;
    logic     ch_next;
    logic     load_dmul;
    logic     write_duty;
    logic     write_chan;
    logic     set_status;
    status_e  status;
  } cmd_t;

  typedef struct packed {
    opcode_e opcode;
    logic    req_bad;
    logic    partial;
    logic    set_freq;
    logic    set_duty;
    logic    bot_zero;
    logic    presc_over;
    logic    ch_active;
    logic    ch_last;
    logic    duty_bad;
    logic    div_done;
  } sts_t;

endpackage

// ===== hw/rtl/pcse_divider.sv =====
module pcse_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pcse_pkg::DIVD_W-1:0]   dividend_i,
  input  logic [pcse_pkg::DIVS_W-1:0]   divisor_i,
  output logic                          done_o,
  output logic [pcse_pkg::DIVD_W-1:0]   quotient_o
);

  localparam int unsigned CNT_W = $clog2(pcse_pkg::DIVD_W + 1);

  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic                          done_q, done_d;
  logic [pcse_pkg::DIVS_W-1:0]   rem_q, rem_d, dvs_q;
  logic [pcse_pkg::DIVD_W-1:0]   quo_q, quo_d;
  logic [pcse_pkg::DIVS_W:0]     shifted, trial;

  // one quotient bit per cycle, restoring
  always_comb begin
    shifted = {rem_q, quo_q[pcse_pkg::DIVD_W-1]};
    trial   = shifted - {1'b0, dvs_q};
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    rem_d   = rem_q;
    quo_d   = quo_q;
    if (start_i) begin
      cnt_d = CNT_W'(pcse_pkg::DIVD_W);
      rem_d = '0;
      quo_d = dividend_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = trial[pcse_pkg::DIVS_W-1:0];
        quo_d = {quo_q[pcse_pkg::DIVD_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[pcse_pkg::DIVS_W-1:0];
        quo_d = {quo_q[pcse_pkg::DIVD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // operand and partial remainder
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== hw/rtl/pcse_datapath.sv =====
module pcse_datapath #(
  parameter int unsigned NUM_CHANNELS = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i,
  input  pcse_pkg::in_t     in_data_i,
  input  pcse_pkg::cmd_t    cmd_i,
  output pcse_pkg::sts_t    sts_o,
  output pcse_pkg::out_t    out_data_o
);

  pcse_pkg::in_t    item_q;
  logic [31:0]      core_num_q;
  logic [15:0]      core_den_q;
  logic             wide_q;
  logic [15:0]      remap_q;
  logic             started_q;
  logic [3:0]       en_q, pol_q;
  logic [15:0]      presc_q;
  logic [31:0]      period_q;
  logic [31:0]      cmp_q [pcse_pkg::MAX_CH];
  pcse_pkg::status_e status_q;
  logic [pcse_pkg::CH_W-1:0] ci_q;
  logic [47:0]      top_q, bot_q, scale_q;
  logic [63:0]      prod_q;

  logic [63:0]      div_dvd, quotient;
  logic [47:0]      div_dvs;
  logic             div_done;
  logic [3:0]       phys;
  logic [pcse_pkg::CH_W-1:0] phys_idx;
  logic [15:0]      presc_new;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      core_num_q <= 32'd1;
      core_den_q <= 16'd1;
      wide_q     <= 1'b0;
      remap_q    <= '0;
    end else if (cfg_we_i) begin
      case (pcse_pkg::cfg_reg_e'(cfg_idx_i))
        pcse_pkg::REG_CORE_NUM: core_num_q <= cfg_data_i;
        pcse_pkg::REG_CORE_DEN: core_den_q <= cfg_data_i[15:0];
        pcse_pkg::REG_WIDE:     wide_q     <= cfg_data_i[0];
        pcse_pkg::REG_REMAP:    remap_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // logical to physical channel
  always_comb begin
    phys     = (remap_q == '0) ? {2'b00, ci_q} : remap_q[ci_q*4 +: 4];
    phys_idx = phys[pcse_pkg::CH_W-1:0];
  end

  // prescaler from the scale
  always_comb begin
    presc_new = wide_q ? scale_q[47:32] : scale_q[31:16];
  end

  // divider operands
  always_comb begin
    case (cmd_i.div_sel)
      pcse_pkg::DIV_SCALE: begin
        div_dvd = {16'd0, top_q};
        div_dvs = bot_q;
      end
      pcse_pkg::DIV_PERIOD: begin
        div_dvd = {16'd0, scale_q};
        div_dvs = {31'd0, {1'b0, presc_new} + 17'd1};
      end
      default: begin
        div_dvd = prod_q;
        div_dvs = {16'd0, item_q.duty_den};
      end
    endcase
  end

  pcse_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // item, operands and intermediates
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= in_data_i;
    end
    if (cmd_i.load_fmul) begin
      top_q <= 48'(core_num_q) * 48'(item_q.freq_den);
      bot_q <= 48'(core_den_q) * 48'(item_q.freq_num);
    end
    if (cmd_i.latch_scale) begin
      scale_q <= quotient[47:0];
    end
    if (cmd_i.load_dmul) begin
      prod_q <= {32'd0, item_q.duty_num} * {32'd0, period_q};
    end
  end

  // timer setup state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      en_q      <= '0;
      pol_q     <= '0;
      presc_q   <= '0;
      period_q  <= '0;
      status_q  <= pcse_pkg::ST_OK;
      ci_q      <= '0;
      for (int i = 0; i < pcse_pkg::MAX_CH; i++) begin
        cmp_q[i] <= '0;
      end
    end else begin
      if (cmd_i.do_start) begin
        started_q <= 1'b1;
      end
      if (cmd_i.do_stop) begin
        started_q <= 1'b0;
        en_q      <= '0;
      end
      if (cmd_i.write_freq) begin
        presc_q  <= presc_new;
        period_q <= quotient[31:0];
      end
      if (cmd_i.ch_clear) begin
        ci_q <= '0;
      end else if (cmd_i.ch_next) begin
        ci_q <= ci_q + pcse_pkg::CH_W'(1);
      end
      if (cmd_i.write_duty) begin
        cmp_q[phys_idx] <= quotient[31:0];
      end
      if (cmd_i.write_chan) begin
        en_q[phys_idx] <= 1'b1;
        if (item_q.set_polarity) begin
          pol_q[phys_idx] <= ~item_q.active_high;
        end
      end
      if (cmd_i.set_status) begin
        status_q <= cmd_i.status;
      end
    end
  end

  // status towards the controller
  always_comb begin
    sts_o.opcode     = pcse_pkg::opcode_e'(item_q.opcode);
    sts_o.req_bad    = (item_q.ch_mask == '0) || !started_q;
    sts_o.partial    = (item_q.ch_mask | en_q) != item_q.ch_mask;
    sts_o.set_freq   = item_q.set_freq;
    sts_o.set_duty   = item_q.set_duty;
    sts_o.bot_zero   = (bot_q == '0);
    sts_o.presc_over = !wide_q && ((scale_q[47:16] & pcse_pkg::PRESC_OVER) != '0);
    sts_o.ch_active  = item_q.ch_mask[ci_q] && (phys < 4'(NUM_CHANNELS));
    sts_o.ch_last    = (ci_q == pcse_pkg::CH_W'(NUM_CHANNELS - 1));
    sts_o.duty_bad   = (item_q.duty_num > item_q.duty_den) || (item_q.duty_den == '0);
    sts_o.div_done   = div_done;
  end

  // result beat
  always_comb begin
    out_data_o.status            = status_q;
    out_data_o.prescaler         = presc_q;
    out_data_o.period            = period_q;
    out_data_o.compare_ch0       = cmp_q[0];
    out_data_o.compare_ch1       = (NUM_CHANNELS > 1) ? cmp_q[1] : '0;
    out_data_o.compare_ch2       = (NUM_CHANNELS > 2) ? cmp_q[2] : '0;
    out_data_o.compare_ch3       = (NUM_CHANNELS > 3) ? cmp_q[3] : '0;
    out_data_o.enable_mask       = en_q;
    out_data_o.low_polarity_mask = pol_q;
    out_data_o.running           = started_q;
  end

endmodule

// ===== hw/rtl/pcse_controller.sv =====
module pcse_controller (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  pcse_pkg::sts_t  sts_i,
  output pcse_pkg::cmd_t  cmd_o
);

  pcse_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcse_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pcse_pkg::S_IDLE: if (in_valid_i) state_d = pcse_pkg::S_DECODE;
      pcse_pkg::S_DECODE: begin
        if (sts_i.opcode != pcse_pkg::OP_CONFIG || sts_i.req_bad) begin
          state_d = pcse_pkg::S_RESP;
        end else if (sts_i.set_freq) begin
          state_d = sts_i.partial ? pcse_pkg::S_RESP : pcse_pkg::S_FMUL;
        end else begin
          state_d = pcse_pkg::S_CHAN;
        end
      end
      pcse_pkg::S_FMUL:   state_d = sts_i.bot_zero ? pcse_pkg::S_RESP : pcse_pkg::S_FDIV_S;
      pcse_pkg::S_FDIV_S: state_d = pcse_pkg::S_FDIV_W;
      pcse_pkg::S_FDIV_W: if (sts_i.div_done) state_d = pcse_pkg::S_PDIV_S;
      pcse_pkg::S_PDIV_S: state_d = sts_i.presc_over ? pcse_pkg::S_RESP : pcse_pkg::S_PDIV_W;
      pcse_pkg::S_PDIV_W: if (sts_i.div_done) state_d = pcse_pkg::S_CHAN;
      pcse_pkg::S_CHAN: begin
        if (sts_i.ch_active && sts_i.set_duty) begin
          state_d = sts_i.duty_bad ? pcse_pkg::S_RESP : pcse_pkg::S_DMUL;
        end else if (sts_i.ch_last) begin
          state_d = pcse_pkg::S_RESP;
        end
      end
      pcse_pkg::S_DMUL:   state_d = pcse_pkg::S_DDIV_S;
      pcse_pkg::S_DDIV_S: state_d = pcse_pkg::S_DDIV_W;
      pcse_pkg::S_DDIV_W: begin
        if (sts_i.div_done) begin
          state_d = sts_i.ch_last ? pcse_pkg::S_RESP : pcse_pkg::S_CHAN;
        end
      end
      pcse_pkg::S_RESP:   if (out_ready_i) state_d = pcse_pkg::S_IDLE;
      default:            state_d = pcse_pkg::S_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd_o       = '0;
    cmd_o.div_sel = pcse_pkg::DIV_SCALE;
    cmd_o.status  = pcse_pkg::ST_OK;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      pcse_pkg::S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      pcse_pkg::S_DECODE: begin
        cmd_o.set_status = 1'b1;
        cmd_o.ch_clear   = 1'b1;
        cmd_o.load_fmul  = 1'b1;
        case (sts_i.opcode)
          pcse_pkg::OP_START: cmd_o.do_start = 1'b1;
          pcse_pkg::OP_STOP:  cmd_o.do_stop  = 1'b1;
          pcse_pkg::OP_CONFIG: begin
            if (sts_i.req_bad) begin
              cmd_o.status = pcse_pkg::ST_INVALID;
            end else if (sts_i.set_freq && sts_i.partial) begin
              cmd_o.status = pcse_pkg::ST_NOTSUP;
            end
          end
          default: cmd_o.status = pcse_pkg::ST_INVALID;
        endcase
      end
      pcse_pkg::S_FMUL: begin
        cmd_o.set_status = sts_i.bot_zero;
        cmd_o.status     = pcse_pkg::ST_RANGE;
        cmd_o.div_start  = !sts_i.bot_zero;
        cmd_o.div_sel    = pcse_pkg::DIV_SCALE;
      end
      pcse_pkg::S_FDIV_S: cmd_o.div_sel = pcse_pkg::DIV_SCALE;
      pcse_pkg::S_FDIV_W: cmd_o.latch_scale = sts_i.div_done;
      pcse_pkg::S_PDIV_S: begin
        cmd_o.set_status = sts_i.presc_over;
        cmd_o.status     = pcse_pkg::ST_RANGE;
        cmd_o.div_start  = !sts_i.presc_over;
        cmd_o.div_sel    = pcse_pkg::DIV_PERIOD;
      end
      pcse_pkg::S_PDIV_W: begin
        cmd_o.div_sel    = pcse_pkg::DIV_PERIOD;
        cmd_o.write_freq = sts_i.div_done;
      end
      pcse_pkg::S_CHAN: begin
        if (sts_i.ch_active && sts_i.set_duty) begin
          cmd_o.set_status = sts_i.duty_bad;
          cmd_o.status     = pcse_pkg::ST_RANGE;
        end else begin
          cmd_o.write_chan = sts_i.ch_active;
          cmd_o.ch_next    = !sts_i.ch_last;
        end
      end
      pcse_pkg::S_DMUL: begin
        cmd_o.load_dmul = 1'b1;
        cmd_o.div_sel   = pcse_pkg::DIV_DUTY;
      end
      pcse_pkg::S_DDIV_S: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = pcse_pkg::DIV_DUTY;
      end
      pcse_pkg::S_DDIV_W: begin
        cmd_o.div_sel    = pcse_pkg::DIV_DUTY;
        cmd_o.write_duty = sts_i.div_done;
        cmd_o.write_chan = sts_i.div_done;
        cmd_o.ch_next    = sts_i.div_done && !sts_i.ch_last;
      end
      pcse_pkg::S_RESP: out_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/pwm_channel_setup_engine.sv =====
// start, stop and beats rejected at decode go from accept through the decode state to the result
// configure without a frequency change visits the channel state once per logical channel
// a frequency change adds two 64-step divisions in the shared divider
// each active channel with a duty change adds a 64-step division in the shared divider
// one beat at a time: the next beat is accepted only after the result is taken
// reset: asynchronous active low, clears timer setup and restores register defaults
module pwm_channel_setup_engine #(
  parameter int unsigned NUM_CHANNELS = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [31:0]     cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pcse_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pcse_pkg::out_t  out_data_o
);

  pcse_pkg::cmd_t cmd;
  pcse_pkg::sts_t sts;

  pcse_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pcse_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule
